>>> rtl/rts_remote_frame_encoder_unit_assert.svh
// Assertion macros used by the checker file of the frame encoder.
`ifndef RTS_REMOTE_FRAME_ENCODER_UNIT_ASSERT_SVH
`define RTS_REMOTE_FRAME_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the clock and muted during reset.
`define RTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the clock and muted during reset.
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/rts_pkg.sv
// Shared types and constants of the rolling-code remote frame encoder.
`default_nettype none

package rts_pkg;

    typedef enum logic [1:0] {
        FUNC_NEW    = 2'd0,
        FUNC_REPEAT = 2'd1,
        FUNC_RESET  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    localparam logic CFG_REMOTE_ADDRESS = 1'b0;
    localparam logic CFG_SYMBOL_US      = 1'b1;

    localparam int ADDR_W    = 24;
    localparam int SYMBOL_W  = 12;
    localparam int DUR_W     = 17;
    localparam int FRAME_W   = 56;
    localparam int CODE_W    = 16;

    localparam logic [SYMBOL_W-1:0] SYMBOL_RESET = 12'd640;
    localparam logic [CODE_W-1:0]   CODE_RESET   = 16'd1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        t_func      func;
        logic [3:0] command;
    } t_req;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] first_us;
        logic [DUR_W-1:0] second_us;
        logic [2:0]       count;
        logic             last;
    } t_seg;

    // One queued job: the frame to send and whether the wake-up precedes it.
    typedef struct packed {
        logic               wake;
        logic [FRAME_W-1:0] frame;
    } t_job;

endpackage

`default_nettype wire

>>> rtl/rts_front.sv
// Request front end: rolling code, frame build and job hand-off to the queue.
`default_nettype none

module rts_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire rts_pkg::t_req                 i_req,
    input  wire logic [rts_pkg::ADDR_W-1:0]    i_remote_address,
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output rts_pkg::t_job                      o_q_job
);
    import rts_pkg::*;

    logic [CODE_W-1:0]  r_counter;
    logic [FRAME_W-1:0] r_kept;
    logic [FRAME_W-1:0] n_frame;
    logic               w_accept;

    function automatic logic [FRAME_W-1:0] make_frame(
        input logic [3:0]        command,
        input logic [CODE_W-1:0] code,
        input logic [ADDR_W-1:0] addr
    );
        logic [7:0] b [7];
        logic [3:0] sum;
        logic [FRAME_W-1:0] f;
        b[0] = 8'hA7;
        b[1] = {command, 4'h0};
        b[2] = code[15:8];
        b[3] = code[7:0];
        b[4] = addr[23:16];
        b[5] = addr[15:8];
        b[6] = addr[7:0];
        sum = 4'h0;
        for (int i = 0; i < 7; i++) begin
            sum = sum ^ b[i][7:4] ^ b[i][3:0];
        end
        b[1][3:0] = sum;
        // Each byte is chained with the already obfuscated byte before it.
        for (int i = 1; i < 7; i++) begin
            b[i] = b[i] ^ b[i-1];
        end
        f = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
        return f;
    endfunction

    assign o_req_ready = !i_q_full;
    assign w_accept    = i_req_valid && o_req_ready;
    assign n_frame     = make_frame(i_req.command, r_counter, i_remote_address);

    assign o_q_push = w_accept && (i_req.func == FUNC_NEW || i_req.func == FUNC_REPEAT);

    always_comb begin
        o_q_job.wake  = (i_req.func == FUNC_NEW);
        o_q_job.frame = (i_req.func == FUNC_NEW) ? n_frame : r_kept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= CODE_RESET;
            r_kept    <= '0;
        end else if (w_accept) begin
            case (i_req.func)
                FUNC_NEW: begin
                    r_counter <= r_counter + 1'b1;
                    r_kept    <= n_frame;
                end
                FUNC_RESET: begin
                    r_counter <= CODE_RESET;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/rts_queue.sv
// Short job queue between the request front end and the segment sequencer.
`default_nettype none

module rts_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rts_pkg::t_job i_job,
    input  wire logic          i_pop,
    output rts_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty
);
    import rts_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/rts_back.sv
// Segment sequencer: walks one queued frame and emits its pulse segments.
`default_nettype none

module rts_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [rts_pkg::SYMBOL_W-1:0]   i_symbol_us,
    input  wire rts_pkg::t_job                  i_q_job,
    input  wire logic                           i_q_empty,
    output logic                                o_q_pop,
    output logic                                o_seg_valid,
    input  wire logic                           i_seg_ready,
    output rts_pkg::t_seg                       o_seg
);
    import rts_pkg::*;

    localparam logic [5:0] SEG_WAKE    = 6'd0;
    localparam logic [5:0] SEG_SILENCE = 6'd1;
    localparam logic [5:0] SEG_HWSYNC  = 6'd2;
    localparam logic [5:0] SEG_SWSYNC  = 6'd3;
    localparam logic [5:0] SEG_DATA0   = 6'd4;
    localparam logic [5:0] SEG_GAP     = 6'd60;

    localparam logic [DUR_W-1:0] WAKE_HIGH_US    = 17'd9415;
    localparam logic [DUR_W-1:0] WAKE_LOW_US     = 17'd9565;
    localparam logic [DUR_W-1:0] WAKE_SILENCE_US = 17'd80000;
    localparam logic [DUR_W-1:0] SOFT_SYNC_US    = 17'd4550;
    localparam logic [DUR_W-1:0] GAP_US          = 17'd30415;

    logic               r_busy;
    logic [5:0]         r_idx;
    logic               r_wake;
    logic [FRAME_W-1:0] r_shift;
    logic               r_out_valid;
    t_seg               r_out;
    t_seg               n_seg;
    logic               w_adv;
    logic [DUR_W-1:0]   w_sym;
    logic [DUR_W-1:0]   w_sym4;

    assign w_sym   = DUR_W'(i_symbol_us);
    assign w_sym4  = DUR_W'({i_symbol_us, 2'b00});
    assign w_adv   = r_busy && (!r_out_valid || i_seg_ready);
    assign o_q_pop = !r_busy && !i_q_empty;

    assign o_seg_valid = r_out_valid;
    assign o_seg       = r_out;

    always_comb begin
        n_seg.level     = 1'b0;
        n_seg.first_us  = '0;
        n_seg.second_us = '0;
        n_seg.count     = 3'd1;
        n_seg.last      = 1'b0;
        case (r_idx)
            SEG_WAKE: begin
                n_seg.level     = 1'b1;
                n_seg.first_us  = WAKE_HIGH_US;
                n_seg.second_us = WAKE_LOW_US;
            end
            SEG_SILENCE: begin
                n_seg.first_us = WAKE_SILENCE_US;
            end
            SEG_HWSYNC: begin
                n_seg.level     = 1'b1;
                n_seg.first_us  = w_sym4;
                n_seg.second_us = w_sym4;
                n_seg.count     = r_wake ? 3'd2 : 3'd7;
            end
            SEG_SWSYNC: begin
                n_seg.level     = 1'b1;
                n_seg.first_us  = SOFT_SYNC_US;
                n_seg.second_us = w_sym;
            end
            SEG_GAP: begin
                n_seg.first_us = GAP_US;
                n_seg.last     = 1'b1;
            end
            default: begin
                // Manchester data bit, most significant bit first.
                n_seg.level     = ~r_shift[FRAME_W-1];
                n_seg.first_us  = w_sym;
                n_seg.second_us = w_sym;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_seg;
        end
        if (o_q_pop) begin
            r_shift <= i_q_job.frame;
            r_wake  <= i_q_job.wake;
        end else if (w_adv && r_idx >= SEG_DATA0 && r_idx < SEG_GAP) begin
            r_shift <= {r_shift[FRAME_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= SEG_WAKE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= i_q_job.wake ? SEG_WAKE : SEG_HWSYNC;
            end else if (w_adv) begin
                if (r_idx == SEG_GAP) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_seg_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/rts_remote_frame_encoder_unit.sv
// Top level of the rolling-code remote frame encoder with its configuration registers.
// A new-command item yields 61 segments, a repeat 59.
// The sequencer emits one segment per cycle unless stalled and loads a job while idle.
// An item passes the queue entry, the job load and the output register to the port.
// A two-entry job queue lets further items be accepted while segments still go out.
// Synchronous active-low reset: code 1, kept frame zero, address 0, symbol time 640.
`default_nettype none

module rts_remote_frame_encoder_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire rts_pkg::t_req                 i_req,
    output logic                               o_seg_valid,
    input  wire logic                          i_seg_ready,
    output rts_pkg::t_seg                      o_seg,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [rts_pkg::ADDR_W-1:0]    i_cfg_data
);
    import rts_pkg::*;

    logic [ADDR_W-1:0]   r_remote_address;
    logic [SYMBOL_W-1:0] r_symbol_us;
    logic                w_q_push;
    logic                w_q_pop;
    logic                w_q_full;
    logic                w_q_empty;
    t_job                w_push_job;
    t_job                w_head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote_address <= '0;
            r_symbol_us      <= SYMBOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REMOTE_ADDRESS: r_remote_address <= i_cfg_data;
                CFG_SYMBOL_US:      r_symbol_us      <= i_cfg_data[SYMBOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rts_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_req_valid),
        .o_req_ready      (o_req_ready),
        .i_req            (i_req),
        .i_remote_address (r_remote_address),
        .i_q_full         (w_q_full),
        .o_q_push         (w_q_push),
        .o_q_job          (w_push_job)
    );

    rts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_push_job),
        .i_pop   (w_q_pop),
        .o_job   (w_head_job),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    rts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_symbol_us (r_symbol_us),
        .i_q_job     (w_head_job),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .o_seg_valid (o_seg_valid),
        .i_seg_ready (i_seg_ready),
        .o_seg       (o_seg)
    );

endmodule

`default_nettype wire

>>> rtl/rts_checker.sv
// Port-level checker for the frame encoder and its bind to the top level.
`default_nettype none

`include "rts_remote_frame_encoder_unit_assert.svh"

module rts_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_seg_valid,
    input  wire logic                          i_seg_ready,
    input  wire rts_pkg::t_seg                 o_seg
);
    import rts_pkg::*;

    logic w_seg_stalled;
    logic w_seg_repeats;
    logic w_sync_shape;
    logic w_seg_final;
    logic w_gap_shape;
    logic w_seg_silence;
    logic w_silence_shape;

    assign w_seg_stalled   = o_seg_valid && !i_seg_ready;
    assign w_seg_repeats   = o_seg_valid && o_seg.count != 3'd1;
    assign w_sync_shape    = o_seg.level && (o_seg.count == 3'd2 || o_seg.count == 3'd7);
    assign w_seg_final     = o_seg_valid && o_seg.last;
    assign w_gap_shape     = !o_seg.level && o_seg.first_us == 17'd30415
                             && o_seg.second_us == '0;
    assign w_seg_silence   = o_seg_valid && o_seg.first_us == 17'd80000;
    assign w_silence_shape = !o_seg.level && o_seg.second_us == '0 && !o_seg.last;

    // A stalled segment must stay offered.
    `RTS_ASSERT_NEXT(a_seg_hold, i_clk, i_rst_n, w_seg_stalled, o_seg_valid)

    // Only the hardware sync repeats, and it is always a high-first pulse.
    `RTS_ASSERT_NOW(a_repeat_is_sync, i_clk, i_rst_n, w_seg_repeats, w_sync_shape)

    // The final segment of a run is the inter-frame silence.
    `RTS_ASSERT_NOW(a_last_is_gap, i_clk, i_rst_n, w_seg_final, w_gap_shape)

    // A silence segment never carries a second half.
    `RTS_ASSERT_NOW(a_silence_shape, i_clk, i_rst_n, w_seg_silence, w_silence_shape)

endmodule

bind rts_remote_frame_encoder_unit rts_checker u_rts_checker (.*);

`default_nettype wire
